### src/fbpa_pkg.sv
`timescale 1ns / 1ps
package fbpa_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int IDX_W      = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int ADDR_W     = 32;
  localparam int BB_W       = 17;
  localparam int SIZE_W     = BB_W + 1;
  localparam int PROD_W     = IDX_W + SIZE_W;
  localparam int DIV_STEPS  = ADDR_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_NULL       = 3'd2,
    ST_OUTSIDE    = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_DOUBLE     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_BASE  = 2'd0,
    CFG_BYTES = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_idx_t;

  // request to the serial remainder unit
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  // quotient keeps CNT_W low bits plus a sticky flag for anything larger
  typedef struct packed {
    logic             done;
    logic             rem_zero;
    logic             over;
    logic [CNT_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] push_idx;
  } stk_ctl_t;

endpackage

### src/fbpa_divider.sv
`timescale 1ns / 1ps
module fbpa_divider import fbpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [ADDR_W-1:0] dvd_r;
  logic [SIZE_W-1:0] dvs_r;
  logic [SIZE_W-1:0] rem_r;
  logic [CNT_W-1:0]  quot_r;
  logic              over_r;
  logic              done_r;

  logic [SIZE_W:0]   shifted;
  logic [SIZE_W+1:0] trial;
  logic              qbit;
  logic [SIZE_W-1:0] rem_nxt;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, dvd_r[ADDR_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    qbit    = !trial[SIZE_W+1];
    rem_nxt = qbit ? trial[SIZE_W-1:0] : shifted[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r  <= req.dividend;
      dvs_r  <= req.divisor;
      rem_r  <= '0;
      quot_r <= '0;
      over_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[ADDR_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[CNT_W-2:0], qbit};
      over_r <= over_r | quot_r[CNT_W-1];
    end
  end

  assign res.done     = done_r;
  assign res.rem_zero = (rem_r == '0);
  assign res.over     = over_r;
  assign res.quot     = quot_r;

endmodule

### src/fbpa_stack.sv
`timescale 1ns / 1ps
module fbpa_stack import fbpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  stk_ctl_t         ctl,
  output logic [CNT_W-1:0] depth,
  output logic [IDX_W-1:0] top_idx
);

  logic [IDX_W-1:0] mem [POOL_SLOTS];
  logic [CNT_W-1:0] depth_r;
  logic [CNT_W-1:0] depth_dec;
  logic [IDX_W-1:0] top_r;
  logic             room;

  assign depth_dec = depth_r - 1'b1;
  assign room      = depth_r < CNT_W'(POOL_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (ctl.pop) begin
      depth_r <= depth_dec;
    end else if (ctl.push && room) begin
      depth_r <= depth_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && room) begin
      mem[depth_r[IDX_W-1:0]] <= ctl.push_idx;
    end
    if (ctl.pop) begin
      top_r <= mem[depth_dec[IDX_W-1:0]];
    end
  end

  assign depth   = depth_r;
  assign top_idx = top_r;

endmodule

### src/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------
// in       | in_valid / in_stall    | in_opcode, in_address
// out      | out_valid / out_stall  | out_status, out_block_address, out_used_count
// cfg      | cfg_wr_en (no wait)    | cfg_index, cfg_wr_data
//
// one request at a time; states from acceptance: fresh allocate S_MUL, S_ADD, S_FIN;
// freed-stack allocate S_POP (stack read), S_MUL, S_ADD, S_FIN; exhausted S_FIN; free
// S_DIV (bit-serial remainder, 32 steps), S_FIN; null pointer and below-base S_FIN
// a finished result waits in the output register while the next request is taken
// reset is synchronous, free marks are all set at once, no clearing pass
module fixed_block_pool_allocator import fbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [ADDR_W-1:0] out_block_address,
  output logic [CNT_W-1:0]  out_used_count,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FIN
  } state_t;

  logic [ADDR_W-1:0]     base_r;
  logic [BB_W-1:0]       bytes_r;
  logic [CNT_W-1:0]      count_r;

  state_t                state_r;
  logic [IDX_W-1:0]      idx_r;
  logic [PROD_W-1:0]     prod_r;
  status_t               status_r;
  logic [ADDR_W-1:0]     res_addr_r;
  logic [POOL_SLOTS-1:0] marks_r;
  logic [CNT_W-1:0]      fresh_r;
  logic [CNT_W-1:0]      used_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [CNT_W-1:0]      out_used_r;

  logic [SIZE_W-1:0]     size_sum;
  logic [SIZE_W-1:0]     size_rnd;
  logic [SIZE_W-1:0]     eff_size;
  logic [CNT_W-1:0]      eff_count;
  logic [ADDR_W:0]       offset;
  logic                  accept;
  logic                  out_free;
  logic                  free_outside;
  logic                  free_double;
  logic                  free_good;

  div_req_t              div_req;
  div_res_t              div_res;
  stk_ctl_t              stk_ctl;
  logic [CNT_W-1:0]      stk_depth;
  logic [IDX_W-1:0]      stk_top;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      bytes_r <= BB_W'(16);
      count_r <= CNT_W'(POOL_SLOTS);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE:  base_r  <= cfg_wr_data;
        CFG_BYTES: bytes_r <= cfg_wr_data[BB_W-1:0];
        CFG_COUNT: count_r <= cfg_wr_data[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // size rounded up to 8, at least 16; count clamped to 1..POOL_SLOTS
  always_comb begin
    size_sum = {1'b0, bytes_r} + SIZE_W'(7);
    size_rnd = {size_sum[SIZE_W-1:3], 3'b000};
    eff_size = (size_rnd < SIZE_W'(16)) ? SIZE_W'(16) : size_rnd;
    if (count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (count_r > CNT_W'(POOL_SLOTS)) begin
      eff_count = CNT_W'(POOL_SLOTS);
    end else begin
      eff_count = count_r;
    end
  end

  assign offset   = {1'b0, in_address} - {1'b0, base_r};
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // quotient below count is the same as offset below size * count
  assign free_outside = div_res.over || (div_res.quot >= eff_count);
  assign free_double  = marks_r[div_res.quot[IDX_W-1:0]];
  assign free_good    = div_res.done && !free_outside && div_res.rem_zero && !free_double;

  always_comb begin
    div_req.start    = accept && (in_opcode != OP_ALLOC) && (in_address != '0)
                       && !offset[ADDR_W];
    div_req.dividend = offset[ADDR_W-1:0];
    div_req.divisor  = eff_size;
    stk_ctl.pop      = accept && (in_opcode == OP_ALLOC) && (stk_depth != '0);
    stk_ctl.push     = (state_r == S_DIV) && free_good;
    stk_ctl.push_idx = div_res.quot[IDX_W-1:0];
  end

  fbpa_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  fbpa_stack u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (stk_ctl),
    .depth   (stk_depth),
    .top_idx (stk_top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      marks_r     <= '1;
      fresh_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_addr_r <= '0;
            if (in_opcode == OP_ALLOC) begin
              if (stk_depth != '0) begin
                status_r <= ST_OK;
                state_r  <= S_POP;
              end else if (fresh_r < eff_count) begin
                status_r <= ST_OK;
                idx_r    <= fresh_r[IDX_W-1:0];
                fresh_r  <= fresh_r + 1'b1;
                state_r  <= S_MUL;
              end else begin
                status_r <= ST_EXHAUSTED;
                state_r  <= S_FIN;
              end
            end else if (in_address == '0) begin
              status_r <= ST_NULL;
              state_r  <= S_FIN;
            end else if (offset[ADDR_W]) begin
              status_r <= ST_OUTSIDE;
              state_r  <= S_FIN;
            end else begin
              status_r <= ST_OK;
              state_r  <= S_DIV;
            end
          end
        end
        S_POP: begin
          idx_r   <= stk_top;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= idx_r * eff_size;
          state_r <= S_ADD;
        end
        S_ADD: begin
          res_addr_r     <= base_r + ADDR_W'(prod_r);
          marks_r[idx_r] <= 1'b0;
          used_r         <= used_r + 1'b1;
          state_r        <= S_FIN;
        end
        S_DIV: begin
          if (div_res.done) begin
            state_r <= S_FIN;
            if (free_outside) begin
              status_r <= ST_OUTSIDE;
            end else if (!div_res.rem_zero) begin
              status_r <= ST_MISALIGNED;
            end else if (free_double) begin
              status_r <= ST_DOUBLE;
            end else if (stk_depth < CNT_W'(POOL_SLOTS)) begin
              marks_r[div_res.quot[IDX_W-1:0]] <= 1'b1;
              if (used_r != '0) begin
                used_r <= used_r - 1'b1;
              end
            end
          end
        end
        S_FIN: begin
          // wait until the output register can take the result
          if (out_free) begin
            out_status_r <= status_r;
            out_addr_r   <= res_addr_r;
            out_used_r   <= used_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_used_count    = out_used_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request taken while another is in flight");

  a_fail_has_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_block_address == '0))
    else $error("failed request carries an address");

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_used_count <= CNT_W'(POOL_SLOTS)))
    else $error("used count beyond pool size");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("remainder unit finished outside a free");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
                                  && $stable(out_used_count)))
    else $error("pending result overwritten");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb import fbpa_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    bit                hold_for_drain;
  } pool_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  used_count;
  } pool_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_opcode = 1'b0;
  logic [ADDR_W-1:0] in_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_status;
  logic [ADDR_W-1:0] out_block_address;
  logic [CNT_W-1:0]  out_used_count;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wr_data = '0;

  fixed_block_pool_allocator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_used_count    (out_used_count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pool settings as last written
  logic [ADDR_W-1:0] cfg_base = '0;
  logic [BB_W-1:0]   cfg_block_bytes = 17'd16;
  logic [CNT_W-1:0]  cfg_block_count = 7'd64;

  // allocator state
  logic [IDX_W-1:0]      freed_stack [POOL_SLOTS];
  int                    stack_depth = 0;
  int                    fresh_next = 0;
  bit [POOL_SLOTS-1:0]   free_map = '1;
  int                    used_blocks = 0;

  pool_req_t   pending_reqs[$];
  pool_reply_t expected_replies[$];
  pool_reply_t oldest_reply;

  int  mismatches = 0;
  int  results_checked = 0;
  int  allocs_sent = 0;
  int  frees_sent = 0;
  int  settings_used = 1;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  quiet_tail = 0;
  bit  want_long_hold = 0;
  bit  long_hold_done = 0;
  bit  req_taken;

  function automatic longint unsigned block_size_eff();
    longint unsigned s;
    s = 64'(cfg_block_bytes);
    s = (s + 7) & ~64'd7;
    return (s < 16) ? 64'd16 : s;
  endfunction

  function automatic longint unsigned block_count_eff();
    if (cfg_block_count == 0) return 1;
    if (cfg_block_count > POOL_SLOTS) return POOL_SLOTS;
    return 64'(cfg_block_count);
  endfunction

  task automatic pool_apply(input logic op, input logic [ADDR_W-1:0] addr);
    longint unsigned size, count, off, wide, a64, b64;
    int          idx;
    bit          got;
    pool_reply_t r;
    size = block_size_eff();
    count = block_count_eff();
    r.status = ST_OK;
    r.block_address = '0;
    idx = 0;
    got = 0;
    a64 = 64'(addr);
    b64 = 64'(cfg_base);
    if (op == OP_ALLOC) begin
      if (stack_depth > 0) begin
        stack_depth--;
        idx = int'(freed_stack[stack_depth]);
        got = 1;
      end else if (fresh_next < count) begin
        idx = fresh_next;
        fresh_next++;
        got = 1;
      end
      if (got) begin
        free_map[idx] = 1'b0;
        used_blocks++;
        wide = b64 + longint'(idx) * size;
        r.block_address = wide[ADDR_W-1:0];
      end else begin
        r.status = ST_EXHAUSTED;
      end
    end else begin
      if (a64 == 0) begin
        r.status = ST_NULL;
      end else if (a64 < b64 || a64 - b64 >= size * count) begin
        r.status = ST_OUTSIDE;
      end else begin
        off = a64 - b64;
        if (off % size != 0) begin
          r.status = ST_MISALIGNED;
        end else begin
          idx = int'((off / size) % POOL_SLOTS);
          if (free_map[idx]) begin
            r.status = ST_DOUBLE;
          end else if (stack_depth < POOL_SLOTS) begin
            free_map[idx] = 1'b1;
            freed_stack[stack_depth] = idx[IDX_W-1:0];
            stack_depth++;
            if (used_blocks > 0) used_blocks--;
          end
        end
      end
    end
    r.used_count = used_blocks[CNT_W-1:0];
    expected_replies.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
                               input logic [ADDR_W-1:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
             results_checked, what, got, want);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= OP_ALLOC;
      in_address <= '0;
    end else begin
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        pool_apply(in_opcode, in_address);
        if (in_opcode == OP_ALLOC) allocs_sent++;
        else frees_sent++;
      end
      if (!in_valid || req_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_reqs[0].hold_for_drain && expected_replies.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 99) < 7) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_opcode <= pending_reqs[0].op;
          in_address <= pending_reqs[0].addr;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // result stall generator
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (want_long_hold && !long_hold_done) begin
      long_hold_done = 1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 99) < 8) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        flag_mismatch("result with nothing expected, status", ADDR_W'(out_status), '0);
      end else begin
        oldest_reply = expected_replies.pop_front();
        if (out_status !== oldest_reply.status)
          flag_mismatch("status", ADDR_W'(out_status), ADDR_W'(oldest_reply.status));
        if (out_block_address !== oldest_reply.block_address)
          flag_mismatch("block_address", out_block_address, oldest_reply.block_address);
        if (out_used_count !== oldest_reply.used_count)
          flag_mismatch("used_count", ADDR_W'(out_used_count),
                        ADDR_W'(oldest_reply.used_count));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_replies.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void queue_req(input logic op, input logic [ADDR_W-1:0] addr,
                                    input bit drain);
    pool_req_t q;
    q.op = op;
    q.addr = addr;
    q.hold_for_drain = drain;
    pending_reqs.push_back(q);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_free_address();
    longint unsigned size, count, wide, b64;
    int roll;
    size = block_size_eff();
    count = block_count_eff();
    b64 = 64'(cfg_base);
    roll = $urandom_range(0, 99);
    if (roll < 70)
      wide = b64 + longint'($urandom_range(0, int'(count) - 1)) * size;
    else if (roll < 78)
      wide = b64 + longint'($urandom_range(0, int'(count) - 1)) * size
             + $urandom_range(1, int'(size) - 1);
    else if (roll < 84)
      wide = b64 + count * size;
    else if (roll < 88)
      wide = b64 - 1;
    else if (roll < 92)
      wide = 0;
    else
      wide = $urandom;
    return wide[ADDR_W-1:0];
  endfunction

  task automatic queue_random_phase(input int n, input int alloc_pct);
    bit drain;
    for (int i = 0; i < n; i++) begin
      // every so often the sender waits for all results before going on
      drain = !quiet_tail && (i % 37 == 36);
      if ($urandom_range(0, 99) < alloc_pct)
        queue_req(OP_ALLOC, $urandom, drain);
      else
        queue_req(OP_FREE, pick_free_address(), drain);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    case (idx)
      CFG_BASE:  cfg_base = data;
      CFG_BYTES: cfg_block_bytes = data[BB_W-1:0];
      CFG_COUNT: cfg_block_count = data[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] bytes,
                          input logic [ADDR_W-1:0] blocks);
    write_reg(CFG_BASE, base);
    write_reg(CFG_BYTES, bytes);
    write_reg(CFG_COUNT, blocks);
    settings_used++;
  endtask

  // wait until all requests are out and answered, then let the clock idle
  task automatic settle_pool();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: base 0, 16 byte blocks, 64 blocks
    queue_req(OP_FREE, 32'd0, 0);
    queue_req(OP_ALLOC, 32'd0, 0);
    // block 0 sits at address zero, so freeing it looks like a null pointer
    queue_req(OP_FREE, 32'd0, 0);
    queue_req(OP_ALLOC, 32'hFFFF_FFFF, 0);
    queue_req(OP_FREE, 32'd16, 0);
    queue_req(OP_FREE, 32'd16, 0);
    queue_req(OP_FREE, 32'd8, 0);
    queue_req(OP_FREE, 32'd1024, 0);
    queue_req(OP_FREE, 32'hFFFF_FFFF, 0);
    queue_req(OP_FREE, 32'd48, 0);
    queue_req(OP_ALLOC, 32'd0, 0);
    settle_pool();

    // tiny size rounds up to 16, zero count acts as one block
    set_pool(32'hFFFF_FFF0, 32'd1, 32'd0);
    queue_req(OP_ALLOC, 32'd0, 0);
    queue_req(OP_FREE, 32'hFFFF_FFF0, 0);
    queue_req(OP_ALLOC, 32'd0, 0);
    queue_req(OP_ALLOC, 32'd0, 0);
    queue_req(OP_FREE, 32'hFFFF_FFFF, 0);
    queue_req(OP_FREE, 32'hFFFF_FFF8, 0);
    queue_req(OP_FREE, 32'hFFFF_FFEF, 0);
    settle_pool();

    // count above the pool size clamps; addresses wrap past the top
    set_pool(32'hFFFF_0000, 32'd65536, 32'd127);
    queue_req(OP_ALLOC, 32'd0, 0);
    queue_req(OP_FREE, 32'h0001_0000, 0);
    queue_req(OP_FREE, 32'hFFFF_0000, 0);
    settle_pool();

    // largest size the register holds
    set_pool(32'h4000_0000, 32'd131071, 32'd64);
    queue_req(OP_ALLOC, 32'd0, 0);
    queue_req(OP_FREE, 32'h4000_0000 + 32'd131072 * 32'd63, 0);
    queue_req(OP_FREE, 32'h4000_0000 + 32'd131072 * 32'd64, 0);
    queue_req(OP_ALLOC, 32'd0, 0);
    settle_pool();

    set_pool(32'h0000_1000, 32'd17, 32'd8);
    queue_random_phase(75, 60);
    settle_pool();

    // allocate-heavy on a full size pool, with a long output hold up front
    set_pool(32'd0, 32'd16, 32'd64);
    queue_random_phase(75, 75);
    want_long_hold = 1;
    settle_pool();

    set_pool($urandom, $urandom_range(1, 200), $urandom_range(1, 64));
    queue_random_phase(75, 50);
    settle_pool();

    set_pool(32'hFFFF_FFFF, 32'd65536, 32'd64);
    queue_random_phase(50, 45);
    settle_pool();

    set_pool($urandom & 32'hFFFF_FFF8, $urandom_range(16, 64), $urandom_range(2, 16));
    queue_random_phase(100, 40);
    settle_pool();

    // no idling on either side from here on
    quiet_tail = 1;
    set_pool(32'h0000_0800, 32'd0, 32'd3);
    queue_random_phase(75, 50);
    settle_pool();
    repeat (40) @(posedge clk);

    if (expected_replies.size() != 0)
      flag_mismatch("results never delivered, count", expected_replies.size(), '0);

    $display("checked %0d results from %0d requests (%0d allocate, %0d free)",
             results_checked, allocs_sent + frees_sent, allocs_sent, frees_sent);
    $display("pool settings used: %0d, mismatches: %0d", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
